/* design/triangle_tangent_unit_assert.svh */
// ----------------------------------------------------------------------------
// Triangle tangent unit assertion macros
// Property wrappers used by the top level; they compile away with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_UNIT_ASSERT_SVH
`define TRIANGLE_TANGENT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define TTU_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("triangle_tangent_unit: same-cycle check failed");
`define TTU_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("triangle_tangent_unit: next-cycle check failed");
`else
`define TTU_ASSERT_IMP(lbl, pre, post)
`define TTU_ASSERT_NXT(lbl, pre, post)
`endif

`endif

/* design/ttu_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle tangent unit package
// Shared widths, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
`default_nettype none

package ttu_pkg;

  localparam int POS_W   = 32;
  localparam int TEX_W   = 24;
  localparam int TAN_W   = 16;
  localparam int STEP_W  = 6;
  localparam int DT_W    = TEX_W + 1;
  localparam int DP_W    = POS_W + 1;
  localparam int PROD_W  = DT_W + DP_W;
  localparam int RES_W   = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int NRM_W   = 31;
  localparam int SQ_W    = 2 * NRM_W;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = ROOT_W + 1;
  localparam int SAT_W   = 33;

  localparam logic [1:0] LAST_CORNER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_MUL, ST_ABS, ST_NORM, ST_SQSUM, ST_SQRT, ST_DIV, ST_EMIT
  } ttu_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_DIFF, OP_MUL, OP_ABS, OP_NORM, OP_SQSUM, OP_SQRT, OP_DIV, OP_EMIT
  } ttu_op_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [TEX_W-1:0]      u;
    logic [TEX_W-1:0]      v;
  } ttu_vtx_t;

  typedef struct packed {
    logic              load_vtx;
    logic [1:0]        vtx_slot;
    ttu_op_t           op;
    logic [STEP_W-1:0] step;
    logic [1:0]        corner;
    logic [1:0]        axis;
  } ttu_cmd_t;

  typedef struct packed {
    logic degen;
    logic norm_done;
  } ttu_status_t;

endpackage

`default_nettype wire

/* design/ttu_ctrl.sv */
// ----------------------------------------------------------------------------
// Triangle tangent unit controller
// Counts vertices, sequences the datapath per corner and owns output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_ctrl #(
  parameter int TANGENT_FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ttu_pkg::ttu_cmd_t      cmd,
  input  wire ttu_pkg::ttu_status_t status
);
  import ttu_pkg::*;

  localparam int MUL_LAST   = 4;
  localparam int SQSUM_LAST = 3;
  localparam int SQRT_LAST  = ROOT_W;
  localparam int DIV_LAST   = TANGENT_FRAC_BITS + 3;

  ttu_state_t        state_r, state_nxt;
  logic [1:0]        vcnt_r, vcnt_nxt;
  logic [1:0]        corner_r, corner_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcnt_r      <= '0;
      corner_r    <= '0;
      axis_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      corner_r    <= corner_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    vcnt_nxt      = vcnt_r;
    corner_nxt    = corner_r;
    axis_nxt      = axis_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load_vtx  = 1'b0;
    cmd.vtx_slot  = vcnt_r;
    cmd.op        = OP_NONE;
    cmd.step      = cnt_r;
    cmd.corner    = corner_r;
    cmd.axis      = axis_r;
    in_stall      = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_vtx = 1'b1;
          if (vcnt_r == LAST_CORNER) begin
            vcnt_nxt   = '0;
            corner_nxt = '0;
            state_nxt  = ST_DIFF;
          end else begin
            vcnt_nxt = vcnt_r + 2'd1;
          end
        end
      end
      ST_DIFF: begin
        cmd.op    = OP_DIFF;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        if (cnt_r == STEP_W'(MUL_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ABS;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ABS: begin
        cmd.op    = OP_ABS;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        priority if (status.degen) begin
          state_nxt = ST_EMIT;
        end else if (status.norm_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQSUM;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      ST_SQSUM: begin
        cmd.op = OP_SQSUM;
        if (cnt_r == STEP_W'(SQSUM_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == STEP_W'(SQRT_LAST)) begin
          cnt_nxt   = '0;
          axis_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == STEP_W'(DIV_LAST)) begin
          cnt_nxt = '0;
          if (axis_r == 2'd2) begin
            state_nxt = ST_EMIT;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          if (corner_r == LAST_CORNER) begin
            state_nxt = ST_IDLE;
          end else begin
            corner_nxt = corner_r + 2'd1;
            state_nxt  = ST_DIFF;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/ttu_dpath.sv */
// ----------------------------------------------------------------------------
// Triangle tangent unit datapath
// Vertex store, shared multipliers, normalizer, square root and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_dpath #(
  parameter int TANGENT_FRAC_BITS = 14
) (
  input  wire logic                              clk,
  input  wire logic signed [ttu_pkg::POS_W-1:0]  in_pos_x,
  input  wire logic signed [ttu_pkg::POS_W-1:0]  in_pos_y,
  input  wire logic signed [ttu_pkg::POS_W-1:0]  in_pos_z,
  input  wire logic signed [ttu_pkg::TEX_W-1:0]  in_tex_u,
  input  wire logic signed [ttu_pkg::TEX_W-1:0]  in_tex_v,
  input  wire ttu_pkg::ttu_cmd_t                 cmd,
  output ttu_pkg::ttu_status_t                   status,
  output logic signed [ttu_pkg::TAN_W-1:0]       out_tangent_x,
  output logic signed [ttu_pkg::TAN_W-1:0]       out_tangent_y,
  output logic signed [ttu_pkg::TAN_W-1:0]       out_tangent_z,
  output logic                                   out_degenerate,
  output logic [1:0]                             out_corner,
  output logic                                   out_last
);
  import ttu_pkg::*;

  localparam int F  = TANGENT_FRAC_BITS;
  localparam int QW = F + 2;
  localparam int NW = F + NRM_W + 1;
  localparam logic [SAT_W-1:0] POS_LIM = SAT_W'(32767);
  localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(32768);
  localparam logic [SUM_W-1:0] BIT_TOP = SUM_W'(1) << (SUM_W - 2);

  ttu_vtx_t vtx_r [3];
  ttu_vtx_t va, vb, vc;

  logic signed [DT_W-1:0]   s1_r, t1_r, s2_r, t2_r;
  logic signed [DP_W-1:0]   e1_r [3];
  logic signed [DP_W-1:0]   e2_r [3];
  logic signed [DP_W-1:0]   x0, x1;
  logic signed [PROD_W-1:0] p0_r, p1_r;
  logic signed [RES_W-1:0]  det_r, res_diff;
  logic signed [RES_W-1:0]  comp_r [3];
  logic [MAG_W-1:0]         mag_r [3];
  logic [2:0]               neg_r;
  logic                     det_zero_r;
  logic                     big, small_all, mag_zero;
  logic [NRM_W-1:0]         sq_in;
  logic [SQ_W-1:0]          sq_r;
  logic [SUM_W-1:0]         acc_r;
  logic [SUM_W-1:0]         s_r, r_r, bit_r, trial;
  logic [ROOT_W-1:0]        len;
  logic [NW-1:0]            num;
  logic [REM_W-1:0]         rem_r, rem_t;
  logic [QW-1:0]            quo_r;
  logic                     ge;
  logic [MAG_W-1:0]         mag_sel;
  logic                     neg_sel;
  logic [SAT_W-1:0]         qz;
  logic signed [TAN_W-1:0]  q_sat;
  logic signed [TAN_W-1:0]  tan_r [3];

  // Pivot rotation: corner k uses vertices k, k+1, k+2 (mod 3).
  always_comb begin
    unique case (cmd.corner)
      2'd1: begin
        va = vtx_r[1]; vb = vtx_r[2]; vc = vtx_r[0];
      end
      2'd2: begin
        va = vtx_r[2]; vb = vtx_r[0]; vc = vtx_r[1];
      end
      default: begin
        va = vtx_r[0]; vb = vtx_r[1]; vc = vtx_r[2];
      end
    endcase
  end

  always_comb begin
    unique case (cmd.step)
      STEP_W'(1): begin x0 = e1_r[0]; x1 = e2_r[0]; end
      STEP_W'(2): begin x0 = e1_r[1]; x1 = e2_r[1]; end
      STEP_W'(3): begin x0 = e1_r[2]; x1 = e2_r[2]; end
      default:    begin x0 = DP_W'(s1_r); x1 = DP_W'(s2_r); end
    endcase
  end

  assign res_diff = RES_W'(p0_r) - RES_W'(p1_r);

  always_comb begin
    big       = 1'b0;
    small_all = 1'b1;
    mag_zero  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      big       = big | (|mag_r[i][MAG_W-1:NRM_W]);
      small_all = small_all & ~(|mag_r[i][MAG_W-1:NRM_W-1]);
      mag_zero  = mag_zero & (mag_r[i] == '0);
    end
  end

  assign status.degen     = det_zero_r || mag_zero;
  assign status.norm_done = !big && !small_all;

  always_comb begin
    unique case (cmd.step)
      STEP_W'(0): sq_in = mag_r[0][NRM_W-1:0];
      STEP_W'(1): sq_in = mag_r[1][NRM_W-1:0];
      STEP_W'(2): sq_in = mag_r[2][NRM_W-1:0];
      default:    sq_in = '0;
    endcase
  end

  assign trial = r_r + bit_r;
  assign len   = r_r[ROOT_W-1:0];

  always_comb begin
    unique case (cmd.axis)
      2'd1:    begin mag_sel = mag_r[1]; neg_sel = neg_r[1]; end
      2'd2:    begin mag_sel = mag_r[2]; neg_sel = neg_r[2]; end
      default: begin mag_sel = mag_r[0]; neg_sel = neg_r[0]; end
    endcase
  end

  // Rounded quotient numerator and one restoring division step.
  assign num   = (NW'(mag_sel[NRM_W-1:0]) << F) + NW'(len >> 1);
  assign rem_t = {rem_r[ROOT_W-1:0], quo_r[QW-1]};
  assign ge    = rem_t >= {1'b0, len};

  always_comb begin
    qz = SAT_W'(quo_r);
    if (neg_sel) begin
      q_sat = (qz > NEG_LIM) ? -TAN_W'(32768) : TAN_W'(-qz);
    end else begin
      q_sat = (qz > POS_LIM) ? TAN_W'(32767) : TAN_W'(qz);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vtx) begin
      vtx_r[cmd.vtx_slot] <= '{pos: {in_pos_z, in_pos_y, in_pos_x}, u: in_tex_u, v: in_tex_v};
    end

    unique case (cmd.op)
      OP_DIFF: begin
        s1_r <= DT_W'($signed(vb.u)) - DT_W'($signed(va.u));
        t1_r <= DT_W'($signed(vb.v)) - DT_W'($signed(va.v));
        s2_r <= DT_W'($signed(vc.u)) - DT_W'($signed(va.u));
        t2_r <= DT_W'($signed(vc.v)) - DT_W'($signed(va.v));
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= DP_W'($signed(vb.pos[i])) - DP_W'($signed(va.pos[i]));
          e2_r[i] <= DP_W'($signed(vc.pos[i])) - DP_W'($signed(va.pos[i]));
        end
      end
      OP_MUL: begin
        p0_r <= PROD_W'(t2_r) * PROD_W'(x0);
        p1_r <= PROD_W'(t1_r) * PROD_W'(x1);
        unique case (cmd.step)
          STEP_W'(1): det_r     <= res_diff;
          STEP_W'(2): comp_r[0] <= res_diff;
          STEP_W'(3): comp_r[1] <= res_diff;
          STEP_W'(4): comp_r[2] <= res_diff;
          default: ;
        endcase
      end
      OP_ABS: begin
        det_zero_r <= (det_r == '0);
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= comp_r[i][RES_W-1] ^ det_r[RES_W-1];
          mag_r[i] <= comp_r[i][RES_W-1] ? MAG_W'(-comp_r[i]) : MAG_W'(comp_r[i]);
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= big ? (mag_r[i] >> 1) : (mag_r[i] << 1);
        end
      end
      OP_SQSUM: begin
        sq_r <= SQ_W'(sq_in) * SQ_W'(sq_in);
        acc_r <= (cmd.step == '0) ? '0 : acc_r + SUM_W'(sq_r);
      end
      OP_SQRT: begin
        if (cmd.step == '0) begin
          s_r   <= acc_r;
          r_r   <= '0;
          bit_r <= BIT_TOP;
        end else begin
          if (s_r >= trial) begin
            s_r <= s_r - trial;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      OP_DIV: begin
        if (cmd.step == '0) begin
          rem_r <= REM_W'(num >> QW);
          quo_r <= num[QW-1:0];
        end else if (cmd.step == STEP_W'(QW + 1)) begin
          tan_r[cmd.axis] <= q_sat;
        end else begin
          rem_r <= ge ? (rem_t - {1'b0, len}) : rem_t;
          quo_r <= {quo_r[QW-2:0], ge};
        end
      end
      OP_EMIT: begin
        out_tangent_x  <= status.degen ? '0 : tan_r[0];
        out_tangent_y  <= status.degen ? '0 : tan_r[1];
        out_tangent_z  <= status.degen ? '0 : tan_r[2];
        out_degenerate <= status.degen;
        out_corner     <= cmd.corner;
        out_last       <= (cmd.corner == LAST_CORNER);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/triangle_tangent_unit.sv */
// ----------------------------------------------------------------------------
// Triangle tangent unit
// Per-corner unit tangent vectors of a textured triangle, one vertex a beat.
// ----------------------------------------------------------------------------
// Usage: vertices arrive on the in_ channel, one beat per vertex, three beats
// per triangle. The first two beats are stored and accepted without a stall.
// The third beat starts the computation and the input stalls until all three
// corners have been computed. Each corner produces one beat on the out_
// channel carrying a Q1.F tangent, a degenerate flag, the corner index and a
// last flag on corner 2.
// Each corner runs the edge differences, the products, the magnitudes, the
// normalization by one-bit shifts, the sum of squares, the 32-step square
// root and the three restoring divisions on one shared divider, then emits;
// F is TANGENT_FRAC_BITS. A degenerate corner skips the sum of squares, the
// square root and the divisions.
// The result sits in an output register; a stalled receiver holds it there
// while the next corner is computed, and the controller waits before loading.
// Synchronous reset clears the vertex count and the output valid; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_tangent_unit_assert.svh"

module triangle_tangent_unit #(
  parameter int TANGENT_FRAC_BITS = 14
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [ttu_pkg::POS_W-1:0]  in_pos_x,
  input  wire logic signed [ttu_pkg::POS_W-1:0]  in_pos_y,
  input  wire logic signed [ttu_pkg::POS_W-1:0]  in_pos_z,
  input  wire logic signed [ttu_pkg::TEX_W-1:0]  in_tex_u,
  input  wire logic signed [ttu_pkg::TEX_W-1:0]  in_tex_v,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [ttu_pkg::TAN_W-1:0]       out_tangent_x,
  output logic signed [ttu_pkg::TAN_W-1:0]       out_tangent_y,
  output logic signed [ttu_pkg::TAN_W-1:0]       out_tangent_z,
  output logic                                   out_degenerate,
  output logic [1:0]                             out_corner,
  output logic                                   out_last
);
  import ttu_pkg::*;

  ttu_cmd_t    cmd;
  ttu_status_t status;

  // The controller decides when each step of the corner computation runs.
  ttu_ctrl #(
    .TANGENT_FRAC_BITS(TANGENT_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds the vertices and all arithmetic, and the output payload.
  ttu_dpath #(
    .TANGENT_FRAC_BITS(TANGENT_FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_tex_u      (in_tex_u),
    .in_tex_v      (in_tex_v),
    .cmd           (cmd),
    .status        (status),
    .out_tangent_x (out_tangent_x),
    .out_tangent_y (out_tangent_y),
    .out_tangent_z (out_tangent_z),
    .out_degenerate(out_degenerate),
    .out_corner    (out_corner),
    .out_last      (out_last)
  );

  // The last flag marks exactly the third corner.
  `TTU_ASSERT_IMP(a_last_on_corner2, out_valid, out_last == (out_corner == LAST_CORNER))
  // A degenerate corner carries a zero tangent.
  `TTU_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate, out_tangent_x == 0 && out_tangent_y == 0 && out_tangent_z == 0)
  // After the last corner leaves, a new triangle must arrive before more beats.
  `TTU_ASSERT_NXT(a_gap_after_last, out_valid && !out_stall && out_last, !out_valid)

endmodule

`default_nettype wire
